[src/tmma_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tmma_pkg
// Shared types and constants for the tile multiply-accumulate engine.
// ----------------------------------------------------------------------------
package tmma_pkg;

  localparam int TILE   = 8;
  localparam int CELLS  = TILE * TILE;
  localparam int POS_W  = (TILE > 1) ? $clog2(TILE) : 1;
  localparam int IDX_W  = (CELLS > 1) ? $clog2(CELLS) : 1;

  localparam int TYPE_W = 3;
  localparam int FLD_W  = 3;
  localparam int OP_W   = 16;
  localparam int PROD_W = 2 * OP_W;
  localparam int ACC_W  = 48;

  typedef enum logic [TYPE_W-1:0] {
    REQ_LOAD_A  = 3'd0,
    REQ_LOAD_B  = 3'd1,
    REQ_LOAD_C  = 3'd2,
    REQ_MAC     = 3'd3,
    REQ_READ_C  = 3'd4
  } req_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MAC,
    ST_READ
  } state_e;

  typedef struct packed {
    logic             vld;
    logic             rd;
    logic             first;
    logic             last_k;
    logic             last;
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] col;
  } tag_t;

endpackage
`default_nettype wire

[src/tile_matrix_multiply_accumulate.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tile_matrix_multiply_accumulate
// Tile engine for blocked matrix multiply with Q8.8 operands and saturating
// Q32.16 accumulators.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. Loads of A, B and
// C leave busy low. A multiply-accumulate runs all TILE^3 (512) products
// through one multiplier and one saturating adder, one product per cycle,
// and keeps busy high until the last sum is written back to C. A read of
// the C tile keeps busy high until the last result is out and emits TILE^2
// results in row-major order, one per cycle on consecutive cycles, each
// taken from the registered C RAM read port and marked by out_valid_o for
// exactly one cycle; the receiver cannot stall, so it must take every
// result as it comes. last_o marks the final element.
// ----------------------------------------------------------------------------
module tile_matrix_multiply_accumulate (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic [tmma_pkg::TYPE_W-1:0] req_type_i,
  input  wire logic [tmma_pkg::FLD_W-1:0]  row_i,
  input  wire logic [tmma_pkg::FLD_W-1:0]  col_i,
  input  wire logic [tmma_pkg::OP_W-1:0]   operand_value_i,
  input  wire logic [tmma_pkg::ACC_W-1:0]  accum_value_i,
  output logic                             out_valid_o,
  output logic [tmma_pkg::FLD_W-1:0]       out_row_o,
  output logic [tmma_pkg::FLD_W-1:0]       out_col_o,
  output logic [tmma_pkg::ACC_W-1:0]       c_value_o,
  output logic                             last_o
);

  import tmma_pkg::*;

  state_e            state_q, state_d;
  logic [POS_W-1:0]  i_q, i_d, j_q, j_d, k_q, k_d;
  tag_t              issue, s1_q, s2_tag;
  logic [CELLS-1:0]  c_vld_q;
  logic              c_hit_q;

  logic              accept, in_tile;
  logic [IDX_W-1:0]  ld_addr;
  logic              a_we, b_we, c_we;
  logic [IDX_W-1:0]  c_waddr;
  logic [ACC_W-1:0]  c_wdata;
  logic [IDX_W-1:0]  a_raddr, b_raddr, c_raddr;
  logic [OP_W-1:0]   a_rdata, b_rdata;
  logic [ACC_W-1:0]  c_rdata, c_base, mac_sum;
  logic              mac_we;

  assign accept  = start & ~busy;
  assign in_tile = (32'(row_i) < TILE) && (32'(col_i) < TILE);
  assign ld_addr = IDX_W'(32'(row_i) * TILE + 32'(col_i));

  assign a_we = accept & in_tile & (req_type_i == REQ_LOAD_A);
  assign b_we = accept & in_tile & (req_type_i == REQ_LOAD_B);

  assign mac_we  = s2_tag.vld & ~s2_tag.rd & s2_tag.last_k;
  assign c_we    = mac_we | (accept & in_tile & (req_type_i == REQ_LOAD_C));
  assign c_waddr = mac_we ? IDX_W'(32'(s2_tag.row) * TILE + 32'(s2_tag.col)) : ld_addr;
  assign c_wdata = mac_we ? mac_sum : accum_value_i;

  assign a_raddr = IDX_W'(32'(i_q) * TILE + 32'(k_q));
  assign b_raddr = IDX_W'(32'(k_q) * TILE + 32'(j_q));
  assign c_raddr = IDX_W'(32'(i_q) * TILE + 32'(j_q));

  tmma_ram #(.WIDTH(OP_W), .DEPTH(CELLS)) u_a_ram (
    .clk_i   (clk_i),
    .we_i    (a_we),
    .waddr_i (ld_addr),
    .wdata_i (operand_value_i),
    .raddr_i (a_raddr),
    .rdata_o (a_rdata)
  );

  tmma_ram #(.WIDTH(OP_W), .DEPTH(CELLS)) u_b_ram (
    .clk_i   (clk_i),
    .we_i    (b_we),
    .waddr_i (ld_addr),
    .wdata_i (operand_value_i),
    .raddr_i (b_raddr),
    .rdata_o (b_rdata)
  );

  tmma_ram #(.WIDTH(ACC_W), .DEPTH(CELLS)) u_c_ram (
    .clk_i   (clk_i),
    .we_i    (c_we),
    .waddr_i (c_waddr),
    .wdata_i (c_wdata),
    .raddr_i (c_raddr),
    .rdata_o (c_rdata)
  );

  // C entries never written read as zero
  assign c_base = c_hit_q ? c_rdata : '0;

  tmma_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .tag_i  (s1_q.rd ? tag_t'('0) : s1_q),
    .a_i    (a_rdata),
    .b_i    (b_rdata),
    .base_i (c_base),
    .tag_o  (s2_tag),
    .sum_o  (mac_sum)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      i_q     <= '0;
      j_q     <= '0;
      k_q     <= '0;
      s1_q    <= '0;
      c_hit_q <= 1'b0;
      c_vld_q <= '0;
    end else begin
      state_q <= state_d;
      i_q     <= i_d;
      j_q     <= j_d;
      k_q     <= k_d;
      s1_q    <= issue;
      c_hit_q <= c_vld_q[c_raddr];
      if (c_we) begin
        c_vld_q[c_waddr] <= 1'b1;
      end
    end
  end

  always_comb begin
    state_d = state_q;
    i_d     = i_q;
    j_d     = j_q;
    k_d     = k_q;
    issue   = '0;
    unique case (state_q)
      ST_IDLE: begin
        i_d = '0;
        j_d = '0;
        k_d = '0;
        if (accept && req_type_i == REQ_MAC) begin
          state_d = ST_MAC;
        end else if (accept && req_type_i == REQ_READ_C) begin
          state_d = ST_READ;
        end
      end
      ST_MAC: begin
        issue.vld    = 1'b1;
        issue.first  = (k_q == '0);
        issue.last_k = (k_q == POS_W'(TILE - 1));
        issue.row    = i_q;
        issue.col    = j_q;
        k_d = k_q + 1'b1;
        if (k_q == POS_W'(TILE - 1)) begin
          k_d = '0;
          j_d = j_q + 1'b1;
          if (j_q == POS_W'(TILE - 1)) begin
            j_d = '0;
            i_d = i_q + 1'b1;
            if (i_q == POS_W'(TILE - 1)) begin
              i_d     = '0;
              state_d = ST_IDLE;
            end
          end
        end
      end
      ST_READ: begin
        issue.vld = 1'b1;
        issue.rd  = 1'b1;
        issue.last = (i_q == POS_W'(TILE - 1)) && (j_q == POS_W'(TILE - 1));
        issue.row = i_q;
        issue.col = j_q;
        j_d = j_q + 1'b1;
        if (j_q == POS_W'(TILE - 1)) begin
          j_d = '0;
          i_d = i_q + 1'b1;
          if (i_q == POS_W'(TILE - 1)) begin
            i_d     = '0;
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign busy        = (state_q != ST_IDLE) | s1_q.vld | s2_tag.vld;
  assign out_valid_o = s1_q.vld & s1_q.rd;
  assign out_row_o   = FLD_W'(s1_q.row);
  assign out_col_o   = FLD_W'(s1_q.col);
  assign c_value_o   = c_base;
  assign last_o      = s1_q.last;

endmodule
`default_nettype wire

[src/tmma_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tmma_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module tmma_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule
`default_nettype wire

[src/tmma_mac.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tmma_mac
// Shared multiply-accumulate unit: registered 16x16 product, then a
// 48-bit saturating add into the running accumulator.
// ----------------------------------------------------------------------------
module tmma_mac (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire tmma_pkg::tag_t           tag_i,
  input  wire logic [tmma_pkg::OP_W-1:0]  a_i,
  input  wire logic [tmma_pkg::OP_W-1:0]  b_i,
  input  wire logic [tmma_pkg::ACC_W-1:0] base_i,
  output tmma_pkg::tag_t                tag_o,
  output logic [tmma_pkg::ACC_W-1:0]    sum_o
);

  import tmma_pkg::*;

  tag_t               tag_q;
  logic [PROD_W-1:0]  prod_q;
  logic [ACC_W-1:0]   base_q;
  logic [ACC_W-1:0]   acc_q;
  logic [ACC_W-1:0]   addend;
  logic [ACC_W:0]     sum_wide;
  logic [ACC_W-1:0]   sum_sat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_q <= '0;
    end else begin
      tag_q <= tag_i;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= PROD_W'($signed(a_i) * $signed(b_i));
    base_q <= base_i;
    if (tag_q.vld) begin
      acc_q <= sum_sat;
    end
  end

  always_comb begin
    addend   = tag_q.first ? base_q : acc_q;
    sum_wide = {addend[ACC_W-1], addend}
             + {{(ACC_W + 1 - PROD_W){prod_q[PROD_W-1]}}, prod_q};
    if (sum_wide[ACC_W] != sum_wide[ACC_W-1]) begin
      // overflow: clamp toward the sign of the true sum
      sum_sat = sum_wide[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    end else begin
      sum_sat = sum_wide[ACC_W-1:0];
    end
  end

  assign tag_o = tag_q;
  assign sum_o = sum_sat;

endmodule
`default_nettype wire

[test/tmma_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmma_checker
// Watches the request and result ports of the tile engine. It keeps its own
// copy of the A, B and C tiles and updates them on every accepted in-tile load
// and every multiply-accumulate. Each read of the C tile queues 64 expected
// elements, and each result strobe is compared field by field against the oldest one.
// ----------------------------------------------------------------------------
module tmma_checker (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start,
  input  wire logic                        busy,
  input  wire logic [tmma_pkg::TYPE_W-1:0] req_type_i,
  input  wire logic [tmma_pkg::FLD_W-1:0]  row_i,
  input  wire logic [tmma_pkg::FLD_W-1:0]  col_i,
  input  wire logic [tmma_pkg::OP_W-1:0]   operand_value_i,
  input  wire logic [tmma_pkg::ACC_W-1:0]  accum_value_i,
  input  wire logic                        out_valid_o,
  input  wire logic [tmma_pkg::FLD_W-1:0]  out_row_o,
  input  wire logic [tmma_pkg::FLD_W-1:0]  out_col_o,
  input  wire logic [tmma_pkg::ACC_W-1:0]  c_value_o,
  input  wire logic                        last_o,
  output int                               error_count_o,
  output int                               pending_o
);

  import tmma_pkg::*;

  typedef struct {
    logic [FLD_W-1:0] row;
    logic [FLD_W-1:0] col;
    logic [ACC_W-1:0] value;
    logic             last;
  } c_elem_t;

  localparam longint ACC_HI = (longint'(1) <<< (ACC_W - 1)) - 1;
  localparam longint ACC_LO = -(longint'(1) <<< (ACC_W - 1));

  logic signed [OP_W-1:0]  a_tile [CELLS];
  logic signed [OP_W-1:0]  b_tile [CELLS];
  logic signed [ACC_W-1:0] c_tile [CELLS];
  c_elem_t                 c_readout_q [$];

  task automatic report_mismatch(string msg);
    error_count_o++;
    $display("[%0t] mismatch: %s", $time, msg);
  endtask

  function automatic logic signed [ACC_W-1:0] mac_step(logic signed [ACC_W-1:0] acc,
                                                        logic signed [OP_W-1:0] a,
                                                        logic signed [OP_W-1:0] b);
    longint sum;
    sum = longint'(acc) + longint'(a) * longint'(b);
    if (sum > ACC_HI) return ACC_W'(ACC_HI);
    if (sum < ACC_LO) return ACC_W'(ACC_LO);
    return ACC_W'(sum);
  endfunction

  // C += A * B, B indexed as (k, j), clamped after every k step
  task automatic accumulate_tile();
    logic signed [ACC_W-1:0] acc;
    for (int i = 0; i < TILE; i++) begin
      for (int j = 0; j < TILE; j++) begin
        acc = c_tile[i * TILE + j];
        for (int k = 0; k < TILE; k++) begin
          acc = mac_step(acc, a_tile[i * TILE + k], b_tile[k * TILE + j]);
        end
        c_tile[i * TILE + j] = acc;
      end
    end
  endtask

  task automatic queue_readout();
    c_elem_t elem;
    for (int i = 0; i < TILE; i++) begin
      for (int j = 0; j < TILE; j++) begin
        elem.row   = FLD_W'(i);
        elem.col   = FLD_W'(j);
        elem.value = c_tile[i * TILE + j];
        elem.last  = (i == TILE - 1) && (j == TILE - 1);
        c_readout_q.push_back(elem);
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    c_elem_t want;
    int      idx;
    if (!rst_ni) begin
      foreach (a_tile[n]) a_tile[n] = '0;
      foreach (b_tile[n]) b_tile[n] = '0;
      foreach (c_tile[n]) c_tile[n] = '0;
      c_readout_q.delete();
      pending_o = 0;
    end else begin
      if (out_valid_o) begin
        if (c_readout_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result row %0d col %0d value 0x%012h",
                                    out_row_o, out_col_o, c_value_o));
        end else begin
          want = c_readout_q.pop_front();
          if (out_row_o !== want.row)
            report_mismatch($sformatf("out_row got %0d want %0d", out_row_o, want.row));
          if (out_col_o !== want.col)
            report_mismatch($sformatf("out_col got %0d want %0d", out_col_o, want.col));
          if (c_value_o !== want.value)
            report_mismatch($sformatf("c_value (%0d,%0d) got 0x%012h want 0x%012h",
                                      want.row, want.col, c_value_o, want.value));
          if (last_o !== want.last)
            report_mismatch($sformatf("last (%0d,%0d) got %b want %b",
                                      want.row, want.col, last_o, want.last));
        end
      end
      if (start && !busy) begin
        idx = int'(row_i) * TILE + int'(col_i);
        case (req_type_i)
          REQ_LOAD_A: if (row_i < TILE && col_i < TILE) a_tile[idx] = operand_value_i;
          REQ_LOAD_B: if (row_i < TILE && col_i < TILE) b_tile[idx] = operand_value_i;
          REQ_LOAD_C: if (row_i < TILE && col_i < TILE) c_tile[idx] = accum_value_i;
          REQ_MAC:    accumulate_tile();
          REQ_READ_C: queue_readout();
          default:    ;
        endcase
      end
      pending_o = c_readout_q.size();
    end
  end

endmodule

[test/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the tile multiply-accumulate engine. A directed
// pass reads the reset tile, preloads the four corner accumulators, two of them
// at the rails, and fills A and B so that one multiply-accumulate saturates both ways. Random
// requests follow in bursts with random gaps; the checker does the scoring.
// ----------------------------------------------------------------------------
module tb_top;
  import tmma_pkg::*;

  localparam int SEND_TARGET = 410;
  localparam int MAC_CYCLES  = TILE * TILE * TILE + 2;
  localparam int CYCLE_LIMIT = 400_000;

  localparam logic [TYPE_W-1:0] REQ_SPARE_FIRST = 3'd5;
  localparam logic [TYPE_W-1:0] REQ_SPARE_LAST  = 3'd7;

  localparam logic [OP_W-1:0]  OP_MAX  = {1'b0, {(OP_W - 1){1'b1}}};
  localparam logic [OP_W-1:0]  OP_MIN  = {1'b1, {(OP_W - 1){1'b0}}};
  localparam logic [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W - 1){1'b1}}};
  localparam logic [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W - 1){1'b0}}};

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              start;
  logic              busy;
  logic [TYPE_W-1:0] req_type_i;
  logic [FLD_W-1:0]  row_i;
  logic [FLD_W-1:0]  col_i;
  logic [OP_W-1:0]   operand_value_i;
  logic [ACC_W-1:0]  accum_value_i;
  logic              out_valid_o;
  logic [FLD_W-1:0]  out_row_o;
  logic [FLD_W-1:0]  out_col_o;
  logic [ACC_W-1:0]  c_value_o;
  logic              last_o;
  int                error_count;
  int                pending;
  int                cycle_count = 0;
  int                burst_left  = 0;
  int                issued      = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  tile_matrix_multiply_accumulate u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .req_type_i      (req_type_i),
    .row_i           (row_i),
    .col_i           (col_i),
    .operand_value_i (operand_value_i),
    .accum_value_i   (accum_value_i),
    .out_valid_o     (out_valid_o),
    .out_row_o       (out_row_o),
    .out_col_o       (out_col_o),
    .c_value_o       (c_value_o),
    .last_o          (last_o)
  );

  tmma_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .req_type_i      (req_type_i),
    .row_i           (row_i),
    .col_i           (col_i),
    .operand_value_i (operand_value_i),
    .accum_value_i   (accum_value_i),
    .out_valid_o     (out_valid_o),
    .out_row_o       (out_row_o),
    .out_col_o       (out_col_o),
    .c_value_o       (c_value_o),
    .last_o          (last_o),
    .error_count_o   (error_count),
    .pending_o       (pending)
  );

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic logic [OP_W-1:0] pick_operand();
    case ($urandom_range(0, 7))
      0:       return OP_MAX;
      1:       return OP_MIN;
      2:       return '0;
      3:       return '1;
      default: return OP_W'($urandom);
    endcase
  endfunction

  function automatic logic [ACC_W-1:0] pick_accum();
    case ($urandom_range(0, 7))
      0:       return ACC_MAX;
      1:       return ACC_MIN;
      2:       return ACC_MAX - ACC_W'($urandom);
      3:       return ACC_MIN + ACC_W'($urandom);
      4:       return '0;
      default: return ACC_W'({$urandom, $urandom});
    endcase
  endfunction

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic issue(logic [TYPE_W-1:0] kind, int r, int c,
                       logic [OP_W-1:0] op, logic [ACC_W-1:0] acc);
    if (burst_left == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                : $urandom_range(1, 10);
    end
    burst_left--;
    start           <= 1'b1;
    req_type_i      <= kind;
    row_i           <= FLD_W'(r);
    col_i           <= FLD_W'(c);
    operand_value_i <= op;
    accum_value_i   <= acc;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    issued++;
    @(negedge clk_i);
  endtask

  task automatic issue_random(logic [TYPE_W-1:0] kind);
    issue(kind, $urandom_range(0, TILE - 1), $urandom_range(0, TILE - 1),
          pick_operand(), pick_accum());
  endtask

  task automatic wait_readout_done();
    start <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
  endtask

  initial begin
    int roll;
    rst_ni          = 1'b0;
    start           = 1'b0;
    req_type_i      = '0;
    row_i           = '0;
    col_i           = '0;
    operand_value_i = '0;
    accum_value_i   = '0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: reset tile, spare codes, rail preloads
    issue(REQ_READ_C, 0, 0, '0, '0);
    for (int s = REQ_SPARE_FIRST; s <= REQ_SPARE_LAST; s++) begin
      issue(TYPE_W'(s), TILE - 1, TILE - 1, OP_MAX, ACC_MAX);
    end
    issue(REQ_LOAD_C, 0, 0, OP_MIN, ACC_MAX);
    issue(REQ_LOAD_C, TILE - 1, TILE - 1, OP_MAX, ACC_MIN);
    issue(REQ_LOAD_C, 0, TILE - 1, '0, '1);
    issue(REQ_LOAD_C, TILE - 1, 0, '1, ACC_MAX - 48'd1);

    // row TILE-1 of A drives products negative, other rows positive
    for (int r = 0; r < TILE; r++) begin
      for (int c = 0; c < TILE; c++) begin
        issue(REQ_LOAD_A, r, c, (r == TILE - 1) ? OP_MAX : OP_MIN, '0);
        issue(REQ_LOAD_B, r, c, OP_MIN, '1);
      end
    end
    issue(REQ_MAC, 0, 0, '0, '0);
    issue(REQ_READ_C, TILE - 1, TILE - 1, '1, '1);
    issue(REQ_LOAD_C, 0, 0, '0, '0);
    issue(REQ_MAC, TILE - 1, 0, '1, '0);
    issue(REQ_READ_C, 0, 0, '0, '0);
    wait_readout_done();

    while (issued < SEND_TARGET) begin
      roll = $urandom_range(0, 99);
      if (roll < 30) begin
        issue_random(REQ_LOAD_A);
      end else if (roll < 58) begin
        issue_random(REQ_LOAD_B);
      end else if (roll < 72) begin
        issue_random(REQ_LOAD_C);
      end else if (roll < 80) begin
        issue_random(REQ_MAC);
      end else if (roll < 92) begin
        issue_random(REQ_READ_C);
        if ($urandom_range(0, 7) == 0) wait_readout_done();
      end else begin
        issue_random(TYPE_W'($urandom_range(REQ_SPARE_FIRST, REQ_SPARE_LAST)));
      end
    end

    wait_readout_done();
    repeat (MAC_CYCLES + 16) @(posedge clk_i);
    if (error_count == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
